@@ hdl/wtss_pkg.sv @@
// Shared types, constants and helper functions of the weighted trigger step sequencer.
package wtss_pkg;

    // Pattern length in steps and clock output division.
    localparam int STEPS           = 64;
    localparam int PULSES_PER_BEAT = 4;
    localparam int STEP_W          = $clog2(STEPS);
    localparam int BEAT_W          = (PULSES_PER_BEAT > 1) ? $clog2(PULSES_PER_BEAT) : 1;

    // Channel layout and widths.
    localparam int NUM_CH       = 3;
    localparam int NUM_GATES    = 4;
    localparam int GATE_CLOCK   = 3;
    localparam int WEIGHT_W     = 2;
    localparam int GATE_LEN_W   = 8;
    localparam int KNOB_W       = 10;
    localparam int KNOB_SHIFT   = 10;
    localparam int IDX_OUT_W    = 6;

    localparam logic [GATE_LEN_W-1:0] GATE_LEN_RESET = 8'd25;
    localparam logic [WEIGHT_W-1:0]   WEIGHT_MAX     = 2'b11;

    // One poll of the front panel.
    typedef struct packed {
        logic [NUM_CH-1:0]     button_levels;
        logic                  record_level;
        logic                  advance;
        logic [KNOB_W-1:0]     roll_knob;
        logic [7:0]            elapsed_ms;
    } poll_t;

    // One result of a poll.
    typedef struct packed {
        logic                         gate_top;
        logic                         gate_left;
        logic                         gate_right;
        logic                         clock_gate;
        logic [IDX_OUT_W-1:0]         step_index;
        logic                         recording;
        logic [NUM_CH*WEIGHT_W-1:0]   channel_weights;
    } result_t;

    // Firing threshold: 3 - knob*3/1024, always in 1..3.
    function automatic logic [WEIGHT_W-1:0] knob_threshold(input logic [KNOB_W-1:0] knob);
        logic [KNOB_W+1:0] prod;
        prod = {2'b00, knob} * (KNOB_W+2)'(3);
        return WEIGHT_MAX - prod[KNOB_W+1:KNOB_SHIFT];
    endfunction

    // Move a weight one up when pressed, one down otherwise, clamped to 0..3.
    function automatic logic [WEIGHT_W-1:0] weight_update(input logic [WEIGHT_W-1:0] w,
                                                          input logic pressed);
        logic [WEIGHT_W-1:0] res;
        res = w;
        if (pressed)
        begin
            if (w != WEIGHT_MAX)
                res = w + WEIGHT_W'(1);
        end
        else
        begin
            if (w != '0)
                res = w - WEIGHT_W'(1);
        end
        return res;
    endfunction

endpackage

@@ hdl/wtss_poll_if.sv @@
// Valid/ready channel that carries one poll item.
interface wtss_poll_if;
    logic              valid;
    logic              ready;
    wtss_pkg::poll_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/wtss_result_if.sv @@
// Valid/ready channel that carries one result item.
interface wtss_result_if;
    logic               valid;
    logic               ready;
    wtss_pkg::result_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/weighted_trigger_step_sequencer_core.sv @@
// Top level of the weighted trigger step sequencer: poll processing, pattern memory, gates.
//
// Usage: every poll of the front panel arrives as one transfer on the poll channel
// (buttons, record level, advance flag, roll knob, elapsed milliseconds). Each poll
// produces exactly one transfer on the result channel with the gate levels, the
// current step, the recording flag and the current step's weights.
// A poll accepted on the poll channel passes the input register, then the result
// register, before it is presented on the result channel.
// Throughput: one poll per cycle while result.ready is high; the poll is processed
// in the cycle it leaves the input register, and the weights of the following step
// are prefetched from the pattern memory on every advance so no memory read sits in
// that path. The gate length register is written through cfg_wr_en/cfg_wr_data;
// the user must do so while no poll is in flight; the block does not enforce it.
// Reset: the pattern reads as all zero (per-entry valid bits are cleared at once),
// step, weights, presses, recording and gate timers are cleared, and the gate
// length returns to 25 ms. Polls are accepted right after reset is released.
// Stall: while the receiver holds ready low, the result is held; one more poll is
// taken into the input register and then ready goes low until the result moves.
module weighted_trigger_step_sequencer_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [wtss_pkg::GATE_LEN_W-1:0]     cfg_wr_data,
    wtss_poll_if.sink                           poll,
    wtss_result_if.source                       result
);

    localparam int WW = wtss_pkg::NUM_CH * wtss_pkg::WEIGHT_W;

    // Input stage.
    logic                               in_valid_reg;
    wtss_pkg::poll_t                    in_data_reg;

    // Output stage.
    logic                               out_valid_reg;
    wtss_pkg::result_t                  out_data_reg;
    wtss_pkg::result_t                  out_data_next;

    // Sequencer state.
    logic [wtss_pkg::GATE_LEN_W-1:0]    gate_len_reg;
    logic [wtss_pkg::STEP_W-1:0]        step_reg;
    logic [wtss_pkg::STEP_W-1:0]        step_next;
    logic [wtss_pkg::STEP_W-1:0]        pre_addr;
    logic [wtss_pkg::BEAT_W-1:0]        beat_reg;
    logic [wtss_pkg::BEAT_W-1:0]        beat_next;
    logic [WW-1:0]                      weights_reg;
    logic [WW-1:0]                      weights_next;
    logic [WW-1:0]                      rec_weights;
    logic [wtss_pkg::NUM_CH-1:0]        press_reg;
    logic [wtss_pkg::NUM_CH-1:0]        press_cur;
    logic                               rec_reg;
    logic                               rec_cur;
    logic                               rec_prev_reg;
    logic [wtss_pkg::GATE_LEN_W-1:0]    gate_rem_reg  [wtss_pkg::NUM_GATES];
    logic [wtss_pkg::GATE_LEN_W-1:0]    gate_rem_next [wtss_pkg::NUM_GATES];
    logic [wtss_pkg::NUM_GATES-1:0]     gate_fire;
    logic [wtss_pkg::NUM_GATES-1:0]     gate_level;
    logic [wtss_pkg::WEIGHT_W-1:0]      threshold;

    // Pattern memory with per-entry valid bits and the prefetched next step.
    logic [WW-1:0]                      pattern_mem [wtss_pkg::STEPS];
    logic [wtss_pkg::STEPS-1:0]         mem_valid_reg;
    logic [WW-1:0]                      pre_data_reg;
    logic                               pre_hit_reg;
    logic [WW-1:0]                      pre_weights;

    logic                               move;
    logic                               do_adv;
    logic                               mem_we;

    // Handshake: the input stage empties when the result register can take a new value.
    assign move         = in_valid_reg && (!out_valid_reg || result.ready);
    assign poll.ready   = !in_valid_reg || move;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    assign do_adv  = move && in_data_reg.advance;
    assign mem_we  = do_adv && rec_cur;
    assign pre_weights = pre_hit_reg ? pre_data_reg : '0;
    assign threshold   = wtss_pkg::knob_threshold(in_data_reg.roll_knob);

    // Press latch and record toggle.
    always_comb
    begin
        press_cur = press_reg | in_data_reg.button_levels;
        rec_cur   = rec_reg ^ (in_data_reg.record_level & ~rec_prev_reg);
    end

    // Weights written back while recording.
    always_comb
    begin
        rec_weights = '0;
        for (int i = 0; i < wtss_pkg::NUM_CH; i++)
        begin
            rec_weights[i*wtss_pkg::WEIGHT_W +: wtss_pkg::WEIGHT_W] =
                wtss_pkg::weight_update(weights_reg[i*wtss_pkg::WEIGHT_W +: wtss_pkg::WEIGHT_W],
                                        press_cur[i]);
        end
    end

    // Step, beat, prefetch address and weights after an advance.
    always_comb
    begin
        step_next = (step_reg == wtss_pkg::STEP_W'(wtss_pkg::STEPS - 1)) ?
                    '0 : step_reg + wtss_pkg::STEP_W'(1);
        pre_addr  = (step_next == wtss_pkg::STEP_W'(wtss_pkg::STEPS - 1)) ?
                    '0 : step_next + wtss_pkg::STEP_W'(1);
        if (step_next == '0 || beat_reg == wtss_pkg::BEAT_W'(wtss_pkg::PULSES_PER_BEAT - 1))
            beat_next = '0;
        else
            beat_next = beat_reg + wtss_pkg::BEAT_W'(1);
        weights_next = in_data_reg.advance ? pre_weights : weights_reg;
    end

    // Gate timers: count down by the elapsed time, reload on a fire.
    always_comb
    begin
        gate_fire = '0;
        for (int i = 0; i < wtss_pkg::NUM_CH; i++)
        begin
            gate_fire[i] = in_data_reg.advance &&
                (pre_weights[i*wtss_pkg::WEIGHT_W +: wtss_pkg::WEIGHT_W] >= threshold);
        end
        gate_fire[wtss_pkg::GATE_CLOCK] = in_data_reg.advance && (beat_next == '0);
        for (int g = 0; g < wtss_pkg::NUM_GATES; g++)
        begin
            if (gate_fire[g])
                gate_rem_next[g] = gate_len_reg;
            else if (gate_rem_reg[g] > in_data_reg.elapsed_ms)
                gate_rem_next[g] = gate_rem_reg[g] - in_data_reg.elapsed_ms;
            else
                gate_rem_next[g] = '0;
            gate_level[g] = (gate_rem_next[g] != '0);
        end
    end

    // Result assembly.
    always_comb
    begin
        out_data_next.gate_top        = gate_level[0];
        out_data_next.gate_left       = gate_level[1];
        out_data_next.gate_right      = gate_level[2];
        out_data_next.clock_gate      = gate_level[wtss_pkg::GATE_CLOCK];
        out_data_next.step_index      = wtss_pkg::IDX_OUT_W'(in_data_reg.advance ?
                                                             step_next : step_reg);
        out_data_next.recording       = rec_cur;
        out_data_next.channel_weights = weights_next;
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (poll.ready)
            in_valid_reg <= poll.valid;
    end

    always_ff @(posedge clk)
    begin
        if (poll.valid && poll.ready)
            in_data_reg <= poll.data;
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (move)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (move)
            out_data_reg <= out_data_next;
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gate_len_reg <= wtss_pkg::GATE_LEN_RESET;
        else if (cfg_wr_en)
            gate_len_reg <= cfg_wr_data;
    end

    // Sequencer state update, one poll per transfer out of the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= '0;
            beat_reg     <= '0;
            weights_reg  <= '0;
            press_reg    <= '0;
            rec_reg      <= 1'b0;
            rec_prev_reg <= 1'b0;
            for (int g = 0; g < wtss_pkg::NUM_GATES; g++)
                gate_rem_reg[g] <= '0;
        end
        else if (move)
        begin
            rec_reg      <= rec_cur;
            rec_prev_reg <= in_data_reg.record_level;
            press_reg    <= in_data_reg.advance ? '0 : press_cur;
            weights_reg  <= weights_next;
            for (int g = 0; g < wtss_pkg::NUM_GATES; g++)
                gate_rem_reg[g] <= gate_rem_next[g];
            if (in_data_reg.advance)
            begin
                step_reg <= step_next;
                beat_reg <= beat_next;
            end
        end
    end

    // Pattern memory write and prefetch read; addresses always differ.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            pattern_mem[step_reg] <= rec_weights;
        if (do_adv)
            pre_data_reg <= pattern_mem[pre_addr];
    end

    // Valid bits make unwritten entries read as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_valid_reg <= '0;
            pre_hit_reg   <= 1'b0;
        end
        else
        begin
            if (mem_we)
                mem_valid_reg[step_reg] <= 1'b1;
            if (do_adv)
                pre_hit_reg <= mem_valid_reg[pre_addr];
        end
    end

endmodule

@@ hdl/wtss_checker.sv @@
// Port-level checks of the sequencer top level and the bind that attaches them.
module wtss_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                poll_valid,
    input  logic                poll_ready,
    input  logic                result_valid,
    input  logic                result_ready,
    input  wtss_pkg::result_t   result_data
);

    // A stalled result stays presented and unchanged.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("result changed or dropped while stalled");

    // Polls are refused only while a result waits in the output register.
    a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !poll_ready |-> result_valid)
        else $error("poll channel stalled with an empty result register");

    // A result appearing on an idle output comes from an earlier poll transfer.
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(poll_valid && poll_ready, 2))
        else $error("result appeared without a matching poll transfer");

endmodule

bind weighted_trigger_step_sequencer_core wtss_checker u_wtss_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .poll_valid   (poll.valid),
    .poll_ready   (poll.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_data  (result.data)
);
